>>> hdl/tcf_pkg.sv
// tcf_pkg: types and constants shared by the tilt complementary filter
// holds the payload structs, config register indexes and the cordic angle table
// no dependencies

package tcf_pkg;

    // payload of one input transfer
    typedef struct packed {
        logic signed [15:0] accel_x;
        logic signed [15:0] accel_y;
        logic signed [15:0] gyro_rate;
        logic        [31:0] time_us;
    } t_in_item;

    // payload of one output transfer
    typedef struct packed {
        logic signed [15:0] tilt_angle;
        logic signed [15:0] accel_angle;
        logic signed [15:0] rate_echo;
    } t_out_item;

    // config register indexes
    localparam logic [1:0] CFG_BLEND_GAIN  = 2'd0;
    localparam logic [1:0] CFG_ZERO_OFFSET = 2'd1;

    localparam logic [15:0] GAIN_RESET   = 16'd2621;
    localparam logic [15:0] OFFSET_RESET = 16'd0;

    // cordic vector width: 16 bit counts scaled by 256, quarter turn, gain headroom
    localparam int CW = 28;
    typedef logic signed [CW-1:0] t_vec;

    // serial multiplier and divider sizes
    localparam int MUL_BITS = 16;
    localparam int PROD_W   = 48;
    localparam int NUM_W    = 52;

    // rate*dt*16 + 703125, divided by 1406250, gives the rounded angle step
    localparam logic [20:0] STEP_DIV   = 21'd1406250;
    localparam logic [51:0] STEP_ROUND = 52'd703125;

    localparam logic [31:0] QUARTER_POS = 32'h4000_0000;
    localparam logic [31:0] QUARTER_NEG = 32'hC000_0000;

    // atan(2^-i), 2^32 units per turn
    function automatic logic [31:0] atan_turn(input logic [4:0] idx);
        logic [31:0] v;
        case (idx)
            5'd0:    v = 32'd536870912;
            5'd1:    v = 32'd316933406;
            5'd2:    v = 32'd167458907;
            5'd3:    v = 32'd85004756;
            5'd4:    v = 32'd42667331;
            5'd5:    v = 32'd21354465;
            5'd6:    v = 32'd10679838;
            5'd7:    v = 32'd5340245;
            5'd8:    v = 32'd2670163;
            5'd9:    v = 32'd1335087;
            5'd10:   v = 32'd667544;
            5'd11:   v = 32'd333772;
            5'd12:   v = 32'd166886;
            5'd13:   v = 32'd83443;
            5'd14:   v = 32'd41722;
            5'd15:   v = 32'd20861;
            5'd16:   v = 32'd10430;
            5'd17:   v = 32'd5215;
            5'd18:   v = 32'd2608;
            5'd19:   v = 32'd1304;
            5'd20:   v = 32'd652;
            5'd21:   v = 32'd326;
            5'd22:   v = 32'd163;
            5'd23:   v = 32'd81;
            default: v = 32'd0;
        endcase
        return v;
    endfunction

endpackage

>>> hdl/tilt_complementary_filter_unit.sv
// tilt_complementary_filter_unit: top level of the tilt complementary filter
// iterative cordic atan2, bit-serial multiplier and restoring divider
// depends on tcf_pkg
//
// Usage:
//   input channel  i_in_valid / o_in_ready carries accel x/y, gyro rate and a
//   microsecond timestamp; output channel o_out_valid / i_out_ready carries the
//   filtered tilt angle, the offset-corrected accel angle and the rate echo.
//   Config writes (i_cfg_we, i_cfg_idx, i_cfg_data) land in the cycle after the write.
//   One sample is worked on at a time: cordic, rate*dt multiply, the step
//   divider (one quotient bit a cycle), the blend multiply and control; the
//   next input is taken only once the result has gone to the output register.
//   The first sample after reset only seeds the angle and gives no result.
//   Reset clears the time and angle, arms the first-sample flag and loads the
//   default gain and offset. A stalled receiver holds the result in the output
//   register; the next sample is still taken and worked on, and only its final
//   step waits for the output register to free up.

module tilt_complementary_filter_unit #(
    parameter int CORDIC_STEPS = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  tcf_pkg::t_in_item i_in,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output tcf_pkg::t_out_item o_out,
    input  logic              i_cfg_we,
    input  logic [1:0]        i_cfg_idx,
    input  logic [15:0]       i_cfg_data
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_CORD = 3'd1;
    localparam logic [2:0] ST_ZCAL = 3'd2;
    localparam logic [2:0] ST_MUL1 = 3'd3;
    localparam logic [2:0] ST_DLOD = 3'd4;
    localparam logic [2:0] ST_DIV  = 3'd5;
    localparam logic [2:0] ST_ERR  = 3'd6;
    localparam logic [2:0] ST_MUL2 = 3'd7;

    // control state
    logic [2:0]  r_state, n_state;
    logic        r_fin, n_fin;
    logic        r_out_valid, n_out_valid;
    logic        r_first, n_first;
    logic [31:0] r_last_time, n_last_time;
    logic [15:0] r_last_angle, n_last_angle;
    logic [15:0] r_gain, n_gain;
    logic [15:0] r_offset, n_offset;
    logic [5:0]  r_cnt, n_cnt;

    // datapath
    tcf_pkg::t_vec      r_re, n_re;
    tcf_pkg::t_vec      r_im, n_im;
    logic [31:0]        r_acc, n_acc;
    logic               r_zero, n_zero;
    logic [15:0]        r_rate, n_rate;
    logic [31:0]        r_dt, n_dt;
    logic [15:0]        r_z, n_z;
    logic [tcf_pkg::PROD_W-1:0] r_prod, n_prod;
    logic [15:0]        r_mplier, n_mplier;
    logic [tcf_pkg::NUM_W-1:0]  r_num, n_num;
    logic [20:0]        r_rem, n_rem;
    logic [15:0]        r_q, n_q;
    logic [15:0]        r_pred, n_pred;
    logic               r_err_neg, n_err_neg;
    tcf_pkg::t_out_item r_out, n_out;

    // combinational helpers
    tcf_pkg::t_vec w_cs, w_sn, w_dr, w_di;
    logic [31:0] w_tab, w_acc_rnd, w_mcand, w_round;
    logic [15:0] w_zraw, w_z, w_rate_abs, w_step, w_pred, w_err, w_cmag, w_corr, w_tilt;
    logic [32:0] w_sum;
    logic [21:0] w_trial, w_trial_sub;
    logic        w_ge, w_slot_free, w_in_xfer;

    assign o_in_ready  = (r_state == ST_IDLE) && !r_fin;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    assign w_in_xfer   = i_in_valid && o_in_ready;
    assign w_slot_free = !r_out_valid || i_out_ready;

    // vector scaled by 256
    assign w_cs = {{(tcf_pkg::CW-24){i_in.accel_y[15]}}, i_in.accel_y, 8'h00};
    assign w_sn = {{(tcf_pkg::CW-24){i_in.accel_x[15]}}, i_in.accel_x, 8'h00};

    assign w_dr  = r_im >>> r_cnt[4:0];
    assign w_di  = r_re >>> r_cnt[4:0];
    assign w_tab = tcf_pkg::atan_turn(r_cnt[4:0]);

    assign w_acc_rnd = r_acc + 32'h0000_8000;
    assign w_zraw    = r_zero ? 16'h0000 : w_acc_rnd[31:16];
    assign w_z       = w_zraw - r_offset;

    assign w_rate_abs = r_rate[15] ? 16'(-r_rate) : r_rate;

    // shift-add multiplier, one multiplier bit a cycle
    assign w_mcand = (r_state == ST_MUL1) ? r_dt : {16'h0000, r_gain};
    assign w_sum   = {1'b0, r_prod[tcf_pkg::PROD_W-1:16]}
                   + (r_mplier[0] ? {1'b0, w_mcand} : 33'd0);

    // restoring divider, one quotient bit a cycle
    assign w_trial     = {r_rem, r_num[tcf_pkg::NUM_W-1]};
    assign w_ge        = w_trial >= {1'b0, tcf_pkg::STEP_DIV};
    assign w_trial_sub = w_trial - {1'b0, tcf_pkg::STEP_DIV};

    assign w_step = r_rate[15] ? 16'(-r_q) : r_q;
    assign w_pred = r_last_angle + w_step;
    assign w_err  = r_z - w_pred;

    assign w_round = r_prod[31:0] + 32'h0000_8000;
    assign w_cmag  = w_round[31:16];
    assign w_corr  = r_err_neg ? 16'(-w_cmag) : w_cmag;
    assign w_tilt  = r_pred + w_corr;

    always_comb begin
        n_state      = r_state;
        n_fin        = r_fin;
        n_out_valid  = r_out_valid;
        n_first      = r_first;
        n_last_time  = r_last_time;
        n_last_angle = r_last_angle;
        n_gain       = r_gain;
        n_offset     = r_offset;
        n_cnt        = r_cnt;
        n_re         = r_re;
        n_im         = r_im;
        n_acc        = r_acc;
        n_zero       = r_zero;
        n_rate       = r_rate;
        n_dt         = r_dt;
        n_z          = r_z;
        n_prod       = r_prod;
        n_mplier     = r_mplier;
        n_num        = r_num;
        n_rem        = r_rem;
        n_q          = r_q;
        n_pred       = r_pred;
        n_err_neg    = r_err_neg;
        n_out        = r_out;

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        if (i_cfg_we) begin
            case (i_cfg_idx)
                tcf_pkg::CFG_BLEND_GAIN:  n_gain   = i_cfg_data;
                tcf_pkg::CFG_ZERO_OFFSET: n_offset = i_cfg_data;
                default: ;
            endcase
        end

        if (r_fin) begin
            // blend result waits here for the output register
            if (w_slot_free) begin
                n_out.tilt_angle  = w_tilt;
                n_out.accel_angle = r_z;
                n_out.rate_echo   = r_rate;
                n_out_valid       = 1'b1;
                n_last_angle      = w_tilt;
                n_fin             = 1'b0;
            end
        end else begin
            case (r_state)
                ST_IDLE: begin
                    if (w_in_xfer) begin
                        n_zero      = (i_in.accel_x == 16'sd0) && (i_in.accel_y == 16'sd0);
                        n_rate      = i_in.gyro_rate;
                        n_dt        = i_in.time_us - r_last_time;
                        n_last_time = i_in.time_us;
                        n_cnt       = 6'd0;
                        // left half plane: turn a quarter into the right half
                        if (w_cs[tcf_pkg::CW-1]) begin
                            if (!w_sn[tcf_pkg::CW-1]) begin
                                n_re  = w_sn;
                                n_im  = -w_cs;
                                n_acc = tcf_pkg::QUARTER_POS;
                            end else begin
                                n_re  = -w_sn;
                                n_im  = w_cs;
                                n_acc = tcf_pkg::QUARTER_NEG;
                            end
                        end else begin
                            n_re  = w_cs;
                            n_im  = w_sn;
                            n_acc = 32'd0;
                        end
                        n_state = ST_CORD;
                    end
                end
                ST_CORD: begin
                    if (!r_im[tcf_pkg::CW-1]) begin
                        n_re  = r_re + w_dr;
                        n_im  = r_im - w_di;
                        n_acc = r_acc + w_tab;
                    end else begin
                        n_re  = r_re - w_dr;
                        n_im  = r_im + w_di;
                        n_acc = r_acc - w_tab;
                    end
                    n_cnt = r_cnt + 6'd1;
                    if (r_cnt == 6'(CORDIC_STEPS - 1)) begin
                        n_state = ST_ZCAL;
                    end
                end
                ST_ZCAL: begin
                    n_z = w_z;
                    if (r_first) begin
                        n_last_angle = w_z;
                        n_first      = 1'b0;
                        n_state      = ST_IDLE;
                    end else begin
                        n_prod   = '0;
                        n_mplier = w_rate_abs;
                        n_cnt    = 6'd0;
                        n_state  = ST_MUL1;
                    end
                end
                ST_MUL1, ST_MUL2: begin
                    n_prod   = {w_sum, r_prod[15:1]};
                    n_mplier = {1'b0, r_mplier[15:1]};
                    n_cnt    = r_cnt + 6'd1;
                    if (r_cnt == 6'(tcf_pkg::MUL_BITS - 1)) begin
                        if (r_state == ST_MUL1) begin
                            n_state = ST_DLOD;
                        end else begin
                            n_state = ST_IDLE;
                            n_fin   = 1'b1;
                        end
                    end
                end
                ST_DLOD: begin
                    n_num   = {r_prod, 4'h0} + tcf_pkg::STEP_ROUND;
                    n_rem   = 21'd0;
                    n_cnt   = 6'd0;
                    n_state = ST_DIV;
                end
                ST_DIV: begin
                    n_rem = w_ge ? w_trial_sub[20:0] : w_trial[20:0];
                    n_q   = {r_q[14:0], w_ge};
                    n_num = {r_num[tcf_pkg::NUM_W-2:0], 1'b0};
                    n_cnt = r_cnt + 6'd1;
                    if (r_cnt == 6'(tcf_pkg::NUM_W - 1)) begin
                        n_state = ST_ERR;
                    end
                end
                ST_ERR: begin
                    n_pred    = w_pred;
                    n_err_neg = w_err[15];
                    n_mplier  = w_err[15] ? 16'(-w_err) : w_err;
                    n_prod    = '0;
                    n_cnt     = 6'd0;
                    n_state   = ST_MUL2;
                end
                default: begin
                    n_state = ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_fin        <= 1'b0;
            r_out_valid  <= 1'b0;
            r_first      <= 1'b1;
            r_last_time  <= 32'd0;
            r_last_angle <= 16'd0;
            r_gain       <= tcf_pkg::GAIN_RESET;
            r_offset     <= tcf_pkg::OFFSET_RESET;
            r_cnt        <= 6'd0;
        end else begin
            r_state      <= n_state;
            r_fin        <= n_fin;
            r_out_valid  <= n_out_valid;
            r_first      <= n_first;
            r_last_time  <= n_last_time;
            r_last_angle <= n_last_angle;
            r_gain       <= n_gain;
            r_offset     <= n_offset;
            r_cnt        <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_re      <= n_re;
        r_im      <= n_im;
        r_acc     <= n_acc;
        r_zero    <= n_zero;
        r_rate    <= n_rate;
        r_dt      <= n_dt;
        r_z       <= n_z;
        r_prod    <= n_prod;
        r_mplier  <= n_mplier;
        r_num     <= n_num;
        r_rem     <= n_rem;
        r_q       <= n_q;
        r_pred    <= n_pred;
        r_err_neg <= n_err_neg;
        r_out     <= n_out;
    end

endmodule

>>> bench/tb_tilt_complementary_filter_unit.sv
`timescale 1ns / 1ps
// tb_tilt_complementary_filter_unit: self-checking bench for the tilt complementary filter
// directed table, then random phases; results checked against a local predictor
// depends on tcf_pkg and tilt_complementary_filter_unit

module tb_tilt_complementary_filter_unit;

    localparam int CORDIC_STEPS = 16;
    localparam int SETTLE       = CORDIC_STEPS + 100;
    localparam int CYCLE_LIMIT  = 1000000;
    localparam int DIR_ROWS     = 19;
    localparam int PHASES       = 8;
    localparam int PHASE_ITEMS  = 100;

    // indexes with no register behind them
    localparam logic [1:0] CFG_SPARE_A = 2'd2;
    localparam logic [1:0] CFG_SPARE_B = 2'd3;

    typedef struct packed {
        tcf_pkg::t_in_item  smp;
        logic               typed;
        logic               typed_has;
        tcf_pkg::t_out_item typed_res;
    } t_dir_row;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_ready;
    tcf_pkg::t_in_item  in_pl = '0;
    logic       out_valid;
    logic       out_ready = 1'b0;
    tcf_pkg::t_out_item out_pl;
    logic       cfg_we = 1'b0;
    logic [1:0] cfg_idx = '0;
    logic [15:0] cfg_data = '0;

    // predictor state and register copies
    logic [15:0] gain_r;
    logic [15:0] offset_r;
    logic [31:0] prev_time;
    logic [15:0] prev_angle;
    bit          awaiting_first;
    logic [31:0] atan_lut [0:23];

    tcf_pkg::t_out_item tilt_expect_q [$];
    tcf_pkg::t_out_item exp_head;
    t_dir_row    dir_tab [0:DIR_ROWS-1];
    logic [31:0] clock_us;
    bit          stall_in = 1'b1;
    bit          stall_out = 1'b1;
    int          ready_left = 0;
    int          err_cnt = 0;
    int          cycle_cnt = 0;

    tilt_complementary_filter_unit #(
        .CORDIC_STEPS(CORDIC_STEPS)
    ) u_dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in_valid (in_valid),
        .o_in_ready (in_ready),
        .i_in       (in_pl),
        .o_out_valid(out_valid),
        .i_out_ready(out_ready),
        .o_out      (out_pl),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk) begin
        cycle_cnt <= cycle_cnt + 1;
    end

    initial begin
        wait (cycle_cnt >= CYCLE_LIMIT);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    function automatic int pick_gap();
        int r;
        r = int'($urandom_range(0, 99));
        if (r < 70) return int'($urandom_range(0, 3));
        if (r < 95) return int'($urandom_range(4, 12));
        return int'($urandom_range(30, 150));
    endfunction

    // vectoring cordic, angle in 2^32 units per turn, rounded to 16 bits
    function automatic logic [15:0] accel_bam(input logic signed [15:0] sn,
                                              input logic signed [15:0] cs);
        longint      re, im, t, dr, di;
        logic [31:0] acc;
        int          i;
        re  = longint'(cs) * 256;
        im  = longint'(sn) * 256;
        acc = '0;
        if (sn == 0 && cs == 0) return 16'd0;
        if (re < 0) begin
            if (im >= 0) begin
                t = re; re = im; im = -t; acc = tcf_pkg::QUARTER_POS;
            end else begin
                t = re; re = -im; im = t; acc = tcf_pkg::QUARTER_NEG;
            end
        end
        for (i = 0; i < CORDIC_STEPS && i < 24; i++) begin
            dr = im >>> i;
            di = re >>> i;
            if (im >= 0) begin
                re += dr; im -= di; acc += atan_lut[i];
            end else begin
                re -= dr; im += di; acc -= atan_lut[i];
            end
        end
        acc = acc + 32'h0000_8000;
        return acc[31:16];
    endfunction

    // advances the filter state by one sample; returns 1 when a result follows
    function automatic bit filter_step(input tcf_pkg::t_in_item s,
                                       output tcf_pkg::t_out_item r);
        logic [31:0] dt;
        logic [15:0] z, step, pred, err_u, corr;
        logic [63:0] mag, q;
        longint      rate_l, err_l, cmag;
        r  = '0;
        dt = s.time_us - prev_time;
        prev_time = s.time_us;
        z = accel_bam(s.accel_x, s.accel_y) - offset_r;
        if (awaiting_first) begin
            prev_angle = z;
            awaiting_first = 1'b0;
            return 1'b0;
        end
        rate_l = longint'(s.gyro_rate);
        mag  = 64'(rate_l < 0 ? -rate_l : rate_l) * {32'd0, dt} * 64'd8;
        q    = (64'd2 * mag + 64'd703125) / 64'd1406250;
        step = q[15:0];
        if (rate_l < 0) step = 16'd0 - step;
        pred  = prev_angle + step;
        err_u = z - pred;
        err_l = longint'($signed(err_u));
        cmag  = longint'({48'd0, gain_r}) * (err_l < 0 ? -err_l : err_l);
        cmag  = (cmag + 32768) >>> 16;
        corr  = cmag[15:0];
        if (err_l < 0) corr = 16'd0 - corr;
        prev_angle = pred + corr;
        r.tilt_angle  = prev_angle;
        r.accel_angle = z;
        r.rate_echo   = s.gyro_rate;
        return 1'b1;
    endfunction

    function automatic t_dir_row dir_row(input logic signed [15:0] ax, ay, rate,
                                         input logic [31:0] t, input logic typed, has,
                                         input logic signed [15:0] tilt, acc, echo);
        t_dir_row row;
        row.smp.accel_x   = ax;
        row.smp.accel_y   = ay;
        row.smp.gyro_rate = rate;
        row.smp.time_us   = t;
        row.typed     = typed;
        row.typed_has = has;
        row.typed_res.tilt_angle  = tilt;
        row.typed_res.accel_angle = acc;
        row.typed_res.rate_echo   = echo;
        return row;
    endfunction

    // mostly plausible imu traffic, some junk timestamps and rates
    function automatic tcf_pkg::t_in_item random_sample();
        tcf_pkg::t_in_item s;
        int                r;
        r = int'($urandom_range(0, 99));
        s.accel_x = 16'($urandom);
        s.accel_y = 16'($urandom);
        if ($urandom_range(0, 3) == 0) begin
            s.accel_x = s.accel_x >>> $urandom_range(4, 14);
            s.accel_y = s.accel_y >>> $urandom_range(4, 14);
        end
        if (r < 85) begin
            s.gyro_rate = 16'($urandom_range(0, 4000) - 2000);
            if ($urandom_range(0, 9) == 0) s.gyro_rate = 16'($urandom);
            clock_us = clock_us + $urandom_range(1000, 100000);
        end else begin
            s.gyro_rate = 16'($urandom);
            if (r < 93) clock_us = $urandom;
            else clock_us = clock_us + $urandom_range(0, 3);
        end
        s.time_us = clock_us;
        return s;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("%0t ns: %s mismatch, got %0d expected %0d", $time, what, got, want);
        err_cnt++;
    endtask

    task automatic send_sample(input tcf_pkg::t_in_item smp, input bit typed,
                               input bit typed_has, input tcf_pkg::t_out_item typed_res);
        int                 gap;
        bit                 has;
        tcf_pkg::t_out_item res;
        gap = stall_in ? pick_gap() : 0;
        @(negedge clk);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        in_pl    <= smp;
        do @(posedge clk); while (!in_ready);
        has = filter_step(smp, res);
        if (typed) begin
            has = typed_has;
            res = typed_res;
        end
        if (has) tilt_expect_q.push_back(res);
    endtask

    // sender holds off until every result is back and the block has gone quiet
    task automatic go_idle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (tilt_expect_q.size() != 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
        @(negedge clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
        if (idx == tcf_pkg::CFG_BLEND_GAIN) gain_r = val;
        else if (idx == tcf_pkg::CFG_ZERO_OFFSET) offset_r = val;
    endtask

    always @(negedge clk) begin
        if (ready_left != 0) begin
            ready_left <= ready_left - 1;
        end else if (!stall_out || $urandom_range(0, 2) != 0) begin
            out_ready  <= 1'b1;
            ready_left <= int'($urandom_range(0, 6));
        end else begin
            out_ready  <= 1'b0;
            ready_left <= pick_gap();
        end
    end

    always @(posedge clk) begin
        if (rst_n && out_valid && out_ready) begin
            if (tilt_expect_q.size() == 0) begin
                report_mismatch("unexpected result, tilt_angle", int'(out_pl.tilt_angle), 0);
            end else begin
                exp_head = tilt_expect_q.pop_front();
                if (out_pl.tilt_angle !== exp_head.tilt_angle)
                    report_mismatch("tilt_angle", int'(out_pl.tilt_angle),
                                    int'(exp_head.tilt_angle));
                if (out_pl.accel_angle !== exp_head.accel_angle)
                    report_mismatch("accel_angle", int'(out_pl.accel_angle),
                                    int'(exp_head.accel_angle));
                if (out_pl.rate_echo !== exp_head.rate_echo)
                    report_mismatch("rate_echo", int'(out_pl.rate_echo),
                                    int'(exp_head.rate_echo));
            end
        end
    end

    initial begin : main_seq
        int          k, ph, n;
        logic [15:0] g, o;
        atan_lut = '{32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
                     32'd42667331, 32'd21354465, 32'd10679838, 32'd5340245,
                     32'd2670163, 32'd1335087, 32'd667544, 32'd333772,
                     32'd166886, 32'd83443, 32'd41722, 32'd20861,
                     32'd10430, 32'd5215, 32'd2608, 32'd1304,
                     32'd652, 32'd326, 32'd163, 32'd81};
        gain_r         = tcf_pkg::GAIN_RESET;
        offset_r       = tcf_pkg::OFFSET_RESET;
        prev_time      = '0;
        prev_angle     = '0;
        awaiting_first = 1'b1;

        // first sample seeds only; zero vector with zero rate or zero dt gives readable results
        dir_tab[0]  = dir_row(0, 0, 0, 32'd0, 1, 0, 0, 0, 0);
        dir_tab[1]  = dir_row(0, 0, 0, 32'd1000, 1, 1, 0, 0, 0);
        dir_tab[2]  = dir_row(0, 0, 32767, 32'd1000, 1, 1, 0, 0, 32767);
        dir_tab[3]  = dir_row(0, 0, -32768, 32'd1000, 1, 1, 0, 0, -32768);
        dir_tab[4]  = dir_row(32767, 0, 0, 32'd21000, 0, 0, 0, 0, 0);
        dir_tab[5]  = dir_row(-32768, 0, 0, 32'd41000, 0, 0, 0, 0, 0);
        dir_tab[6]  = dir_row(0, 32767, 0, 32'd61000, 0, 0, 0, 0, 0);
        dir_tab[7]  = dir_row(0, -32768, 0, 32'd81000, 0, 0, 0, 0, 0);
        dir_tab[8]  = dir_row(32767, -32768, -300, 32'd101000, 0, 0, 0, 0, 0);
        dir_tab[9]  = dir_row(-32768, -32768, 300, 32'd121000, 0, 0, 0, 0, 0);
        dir_tab[10] = dir_row(-1, -1, 32767, 32'd141000, 0, 0, 0, 0, 0);
        dir_tab[11] = dir_row(1, 1, -32768, 32'd161000, 0, 0, 0, 0, 0);
        // timestamp steps back, so dt wraps
        dir_tab[12] = dir_row(100, -1, 16, 32'd160999, 0, 0, 0, 0, 0);
        dir_tab[13] = dir_row(-100, 1, -16, 32'hFFFF_FFFF, 0, 0, 0, 0, 0);
        dir_tab[14] = dir_row(5000, 5000, 1000, 32'h0000_0010, 0, 0, 0, 0, 0);
        // long gap at full rate wraps the gyro increment
        dir_tab[15] = dir_row(12345, -23456, -32768, 32'd5000016, 0, 0, 0, 0, 0);
        dir_tab[16] = dir_row(-1, 0, 1, 32'd5010016, 0, 0, 0, 0, 0);
        dir_tab[17] = dir_row(1, -1, 32767, 32'd5020016, 0, 0, 0, 0, 0);
        dir_tab[18] = dir_row(-32768, 32767, 0, 32'd5030016, 0, 0, 0, 0, 0);

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        for (k = 0; k < DIR_ROWS; k++)
            send_sample(dir_tab[k].smp, dir_tab[k].typed, dir_tab[k].typed_has,
                        dir_tab[k].typed_res);
        clock_us = dir_tab[DIR_ROWS-1].smp.time_us;

        for (ph = 0; ph < PHASES; ph++) begin
            go_idle();
            case (ph)
                0: begin g = 16'd0;    o = 16'h8000; end
                1: begin g = 16'hFFFF; o = 16'h7FFF; end
                2: begin g = 16'hFFFF; o = 16'h0000; end
                4: begin g = tcf_pkg::GAIN_RESET; o = tcf_pkg::OFFSET_RESET; end
                6: begin g = 16'h8000; o = 16'h4000; end
                default: begin g = 16'($urandom); o = 16'($urandom); end
            endcase
            stall_in  = (ph != 2) && (ph != 5);
            stall_out = (ph != 2) && (ph != 4);
            write_reg(tcf_pkg::CFG_BLEND_GAIN, g);
            write_reg(tcf_pkg::CFG_ZERO_OFFSET, o);
            if (ph == 0 || ph == 5) begin
                write_reg(CFG_SPARE_A, 16'($urandom));
                write_reg(CFG_SPARE_B, 16'($urandom));
            end
            for (n = 0; n < PHASE_ITEMS; n++)
                send_sample(random_sample(), 1'b0, 1'b0, '0);
        end
        go_idle();

        if (err_cnt == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

>>> sim.f
hdl/tcf_pkg.sv
hdl/tilt_complementary_filter_unit.sv
bench/tb_tilt_complementary_filter_unit.sv
